// ===== sv/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package deq_pkg;

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Request codes on the input channel
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_REVERSE    = 3'd6
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_SHIFT_IN  = 2'd1,
    OP_SHIFT_OUT = 2'd2,
    OP_WRITE_END = 2'd3
  } cell_op_t;

endpackage

// ===== sv/deq_if.sv =====
// Valid/ready channel interfaces for request and result beats.
interface deq_in_if #(
  parameter int DATA_WIDTH = 64
);
  logic                  valid;
  logic                  ready;
  deq_pkg::mode_t        mode;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_out_if #(
  parameter int DATA_WIDTH = 64,
  parameter int CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data;
  deq_pkg::status_t      status;
  logic [CNT_W-1:0]      count;
  logic                  empty_res;

  modport source (output valid, output data, output status, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input data, input status, input count,
                  input empty_res, output ready);
endinterface

// ===== sv/deq_cell.sv =====
// One storage cell of the deque chain: holds a word and trades it with its neighbors.
module deq_cell #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 64,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  deq_pkg::cell_op_t     op_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] tap_i,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic [DATA_WIDTH-1:0] tap_o
);
  import deq_pkg::*;

  localparam logic [CNT_W-1:0] MY_POS   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] val_nxt;

  // Pick the next word: shift toward the back, toward the front, or write at the tail
  always_comb begin
    val_nxt = val_r;
    unique case (op_i)
      OP_HOLD:      val_nxt = val_r;
      OP_SHIFT_IN:  val_nxt = left_i;
      OP_SHIFT_OUT: val_nxt = right_i;
      OP_WRITE_END: begin
        if (count_i == MY_POS) begin
          val_nxt = value_i;
        end
      end
      default:      val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

  // Add this word to the tail tap when this cell holds the last entry
  assign tap_o = tap_i | ((count_i == LAST_POS) ? val_r : '0);

endmodule

// ===== sv/double_ended_queue.sv =====
// A request beat yields its result beat in the output register in the following cycle.
// Throughput: one request per cycle while the result side keeps up; the output register
// frees in the same cycle it is taken, and every cell shifts or writes on the accepting edge.
// The physical tail (peek back, or peek front when reversed) is read through the OR tap along the cell chain.
// Reset (rst_n low, synchronous): count, direction flag and output valid clear; stored
// words keep whatever they hold and are never read before a push writes them.
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64
) (
  input logic      clk,
  input logic      rst_n,
  deq_in_if.sink   in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  rev_r;
  logic                  rev_nxt;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [CNT_W-1:0]      cnt_out_r;
  logic                  empty_r;

  logic                  accept;
  logic                  is_empty;
  logic                  is_full;
  cell_op_t              op;

  logic [DATA_WIDTH-1:0] cell_val  [DEPTH];
  logic [DATA_WIDTH-1:0] left_val  [DEPTH];
  logic [DATA_WIDTH-1:0] right_val [DEPTH];
  logic [DATA_WIDTH-1:0] tap_chain [DEPTH+1];

  // Take a beat whenever the output register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_empty    = (count_r == '0);
  assign is_full     = (count_r == FULL_CNT);

  // Decode the request into a chain command and the new control state
  always_comb begin
    op         = OP_HOLD;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_nxt = ST_OK;
    data_nxt   = '0;
    if (accept) begin
      unique case (in_ch.mode)
        MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
            op = (((in_ch.mode == MODE_PUSH_FRONT) != rev_r)) ? OP_SHIFT_IN : OP_WRITE_END;
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            op = (((in_ch.mode == MODE_POP_FRONT) != rev_r)) ? OP_SHIFT_OUT : OP_HOLD;
          end
        end
        MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            data_nxt = ((in_ch.mode == MODE_PEEK_FRONT) != rev_r) ? cell_val[0]
                                                                   : tap_chain[0];
          end
        end
        MODE_REVERSE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rev_nxt = ~rev_r;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // Hold control state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r    <= data_nxt;
      status_r  <= status_nxt;
      cnt_out_r <= count_nxt;
      empty_r   <= (count_nxt == '0);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data      = data_r;
  assign out_ch.status    = status_r;
  assign out_ch.count     = cnt_out_r;
  assign out_ch.empty_res = empty_r;

  // Build the cell chain; the physical front sits in cell 0
  assign tap_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_val[i] = in_ch.value;
    end else begin : g_mid_left
      assign left_val[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_val[i] = '0;
    end else begin : g_mid_right
      assign right_val[i] = cell_val[i+1];
    end

    deq_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk     (clk),
      .op_i    (op),
      .count_i (count_r),
      .value_i (in_ch.value),
      .left_i  (left_val[i]),
      .right_i (right_val[i]),
      .tap_i   (tap_chain[i+1]),
      .val_o   (cell_val[i]),
      .tap_o   (tap_chain[i])
    );
  end

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("deque count above depth");

  // A push into a full deque reports full and leaves the count alone
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_full &&
    (in_ch.mode == MODE_PUSH_BACK || in_ch.mode == MODE_PUSH_FRONT)
    |=> out_valid_r && status_r == ST_FULL && count_r == $past(count_r))
    else $error("push on full deque not rejected");

  // Reversing a non-empty deque flips the direction flag
  a_reverse_flip: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_empty && in_ch.mode == MODE_REVERSE |=> rev_r != $past(rev_r))
    else $error("reverse did not flip direction");

  // Every accepted request leaves a result beat waiting
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && cnt_out_r == count_r)
    else $error("accepted request produced no result");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the double-ended queue: random request beats, predicted replies.
module tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 5;
  localparam int N_ITEMS   = 1550;
  localparam int IDLE_STOP = 3000;

  // Mode 7 is outside the enum; the block must ignore it
  localparam mode_t MODE_UNUSED = mode_t'(3'd7);

  typedef struct {
    mode_t             mode;
    logic [DATA_W-1:0] value;
    bit                drain_first;  // wait for all replies before offering
  } deque_request_t;

  typedef struct {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
  } deque_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  #(.DATA_WIDTH(DATA_W))                in_ch ();
  deq_out_if #(.DATA_WIDTH(DATA_W), .CNT_W(CNT_W)) out_ch ();

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deque_request_t request_q[$];
  deque_reply_t   expected_replies[$];
  int             fail_count = 0;

  // Shadow deque: ring store, physical head, occupancy and direction flag
  logic [DATA_W-1:0] ring [DEPTH];
  logic [3:0]        ring_head = '0;
  logic [CNT_W-1:0]  ring_occ  = '0;
  logic              ring_rev  = 1'b0;

  // Apply one accepted request to the shadow deque and queue its reply
  function automatic void deque_apply(input mode_t m, input logic [DATA_W-1:0] v);
    deque_reply_t r;
    logic [3:0]   slot;
    r.data   = '0;
    r.status = ST_OK;
    case (m)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (ring_occ == CNT_W'(DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          // front push lands on the physical first end unless reversed
          if ((m == MODE_PUSH_FRONT) != ring_rev) begin
            ring_head = ring_head - 4'd1;
            ring[ring_head] = v;
          end else begin
            slot = ring_head + ring_occ[3:0];
            ring[slot] = v;
          end
          ring_occ = ring_occ + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (ring_occ == '0) begin
          r.status = ST_EMPTY;
        end else begin
          if ((m == MODE_POP_FRONT) != ring_rev) ring_head = ring_head + 4'd1;
          ring_occ = ring_occ - 1'b1;
        end
      end
      MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        if (ring_occ == '0) begin
          r.status = ST_EMPTY;
        end else if ((m == MODE_PEEK_FRONT) != ring_rev) begin
          r.data = ring[ring_head];
        end else begin
          slot = ring_head + ring_occ[3:0] - 4'd1;
          r.data = ring[slot];
        end
      end
      MODE_REVERSE: begin
        if (ring_occ == '0) r.status = ST_EMPTY;
        else ring_rev = !ring_rev;
      end
      default: begin
      end
    endcase
    r.count     = ring_occ;
    r.empty_res = (ring_occ == '0);
    expected_replies.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic queue_request(input mode_t m, input logic [DATA_W-1:0] v, input bit drain);
    deque_request_t q;
    q.mode        = m;
    q.value       = v;
    q.drain_first = drain;
    request_q.push_back(q);
  endtask

  // Request driver: bursts of beats with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    deque_request_t next_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // predict the beat taken at this edge
      if (in_ch.valid && in_ch.ready) deque_apply(in_ch.mode, in_ch.value);
      // load the next beat once the current one is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() == 0 ||
                     (request_q[0].drain_first && expected_replies.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          next_req = request_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.mode  <= next_req.mode;
          in_ch.value <= next_req.value;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
            gap_left   = $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Reply receiver: randomly re-chosen stall patterns, plus long holds
  int rx_cycle;
  int rx_pattern;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cycle   = 0;
      rx_pattern = 0;
      hold_left  = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1200 || rx_cycle == 4000) hold_left = 60;
      if (rx_cycle % 150 == 0) rx_pattern = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_pattern)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       out_ch.ready <= (rx_cycle % 4 != 3);
          default: out_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // Reply checker: compare each beat with the oldest prediction
  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply beat: data %h status %0d count %0d",
               out_ch.data, out_ch.status, out_ch.count);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.data !== want.data) begin
          $error("data mismatch: expected %h, got %h", want.data, out_ch.data);
          fail_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, got %0d", want.count, out_ch.count);
          fail_count++;
        end
        if (out_ch.empty_res !== want.empty_res) begin
          $error("empty_res mismatch: expected %0b, got %0b", want.empty_res,
                 out_ch.empty_res);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: stop when no beat moves on either channel for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_STOP) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int          episode_len;
    int          push_pct;
    int          pick;
    mode_t       m;
    bit          drain;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_PUSH_BACK;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    // Empty deque: every read-type request and reverse must fail
    queue_request(MODE_POP_FRONT,  random_word(), 1'b0);
    queue_request(MODE_POP_BACK,   random_word(), 1'b0);
    queue_request(MODE_PEEK_FRONT, random_word(), 1'b0);
    queue_request(MODE_PEEK_BACK,  random_word(), 1'b0);
    queue_request(MODE_REVERSE,    random_word(), 1'b0);
    queue_request(MODE_UNUSED,     '1,            1'b0);
    // Fill from both ends with extreme words, then overflow at both ends, reverse and peek
    for (int i = 0; i < DEPTH; i++) begin
      m = (i % 2 == 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
      if (i == 0)      queue_request(m, '0, 1'b0);
      else if (i == 1) queue_request(m, '1, 1'b0);
      else if (i == 2) queue_request(m, 64'h8000_0000_0000_0001, 1'b0);
      else             queue_request(m, random_word(), 1'b0);
    end
    queue_request(MODE_PUSH_BACK,  random_word(), 1'b0);
    queue_request(MODE_PUSH_FRONT, random_word(), 1'b0);
    queue_request(MODE_REVERSE,    random_word(), 1'b0);
    queue_request(MODE_PEEK_FRONT, random_word(), 1'b0);

    // Episodes: push-heavy, balanced or pop-heavy walks, with some noise
    while (request_q.size() < N_ITEMS) begin
      drain       = (request_q.size() < 30) || ($urandom_range(0, 24) == 0);
      episode_len = $urandom_range(10, 60);
      pick        = $urandom_range(0, 9);
      push_pct    = (pick < 2) ? -1 : (pick < 5) ? 80 : (pick < 7) ? 45 : 20;
      for (int k = 0; k < episode_len; k++) begin
        if (push_pct < 0) begin
          m = mode_t'($urandom_range(0, 7));
        end else if ($urandom_range(0, 99) < push_pct) begin
          m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        end else begin
          pick = $urandom_range(0, 19);
          if (pick < 10)      m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
          else if (pick < 17) m = $urandom_range(0, 1) ? MODE_PEEK_FRONT : MODE_PEEK_BACK;
          else if (pick < 19) m = MODE_REVERSE;
          else                m = MODE_UNUSED;
        end
        queue_request(m, random_word(), drain && k == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all beats to be taken and all replies to arrive
    while (request_q.size() != 0 || in_ch.valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
